FILE: rtl/core/ufcd_pkg.sv
// ----------------------------------------------------------------------------
// ufcd_pkg
// shared types and constants of the union-find cycle detector
// ----------------------------------------------------------------------------
package ufcd_pkg;

    localparam int VERTEX_W     = 14;
    localparam int MAX_VERTICES = 1 << VERTEX_W;
    localparam int COUNT_W      = VERTEX_W + 1;
    localparam int RANK_W       = 4;
    localparam int STATUS_W     = 3;

    typedef logic [VERTEX_W-1:0] t_vertex;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [RANK_W-1:0]   t_rank;

    localparam t_rank  RANK_MAX   = {RANK_W{1'b1}};
    localparam t_count COUNT_FULL = COUNT_W'(MAX_VERTICES);

    typedef enum logic {
        CMD_CLEAR = 1'b0,
        CMD_EDGE  = 1'b1
    } t_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_JOINED  = 3'd0,
        ST_CYCLE   = 3'd1,
        ST_SKIPPED = 3'd2,
        ST_RANGE   = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd_code cmd;
        t_vertex   first_vertex;
        t_vertex   second_vertex;
    } t_cmd;

    typedef struct packed {
        t_status status;
        logic    cycle_seen;
    } t_result;

    // one forest entry: parent link and rank of that vertex
    typedef struct packed {
        t_vertex parent;
        t_rank   rank;
    } t_node;

    typedef struct packed {
        logic    we;
        t_vertex waddr;
        t_node   wdata;
        logic    re;
        t_vertex raddr;
    } t_mem_req;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_done;

endpackage

FILE: rtl/core/ufcd_mem.sv
// ----------------------------------------------------------------------------
// ufcd_mem
// forest store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ufcd_mem (
    input  logic               i_clk,
    input  ufcd_pkg::t_mem_req i_req,
    output ufcd_pkg::t_node    o_rdata
);

    ufcd_pkg::t_node mem [ufcd_pkg::MAX_VERTICES];
    ufcd_pkg::t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ufcd_ctrl.sv
// ----------------------------------------------------------------------------
// ufcd_ctrl
// sequencer: clearing sweep, root walks, path compression and union by rank
// ----------------------------------------------------------------------------
module ufcd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ufcd_pkg::t_cmd     i_item,
    input  ufcd_pkg::t_count   i_active,
    output logic               o_busy,
    output ufcd_pkg::t_done    o_done,
    output ufcd_pkg::t_mem_req o_mem,
    input  ufcd_pkg::t_node    i_rdata
);

    typedef enum logic [7:0] {
        S_SWEEP    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_FIND_RD  = 8'b0000_0100,
        S_FIND_CHK = 8'b0000_1000,
        S_COMP_RD  = 8'b0001_0000,
        S_COMP_CHK = 8'b0010_0000,
        S_UNION    = 8'b0100_0000,
        S_TIE      = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    ufcd_pkg::t_count  r_cnt, n_cnt;
    ufcd_pkg::t_count  r_limit, n_limit;
    logic              r_report, n_report;
    logic              r_cycle, n_cycle;
    logic              r_phase, n_phase;
    ufcd_pkg::t_vertex r_cur, n_cur;
    ufcd_pkg::t_vertex r_start, n_start;
    ufcd_pkg::t_vertex r_v, n_v;
    ufcd_pkg::t_vertex r_root, n_root;
    ufcd_pkg::t_rank   r_rank_root, n_rank_root;
    ufcd_pkg::t_vertex r_root_x, n_root_x;
    ufcd_pkg::t_rank   r_rank_x, n_rank_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_cnt    <= '0;
            r_limit  <= ufcd_pkg::COUNT_FULL;
            r_report <= 1'b0;
            r_cycle  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_limit  <= n_limit;
            r_report <= n_report;
            r_cycle  <= n_cycle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase     <= n_phase;
        r_cur       <= n_cur;
        r_start     <= n_start;
        r_v         <= n_v;
        r_root      <= n_root;
        r_rank_root <= n_rank_root;
        r_root_x    <= n_root_x;
        r_rank_x    <= n_rank_x;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_report    = r_report;
        n_cycle     = r_cycle;
        n_phase     = r_phase;
        n_cur       = r_cur;
        n_start     = r_start;
        n_v         = r_v;
        n_root      = r_root;
        n_rank_root = r_rank_root;
        n_root_x    = r_root_x;
        n_rank_x    = r_rank_x;
        o_mem       = '0;
        o_done      = '0;

        unique case (r_state)
            S_SWEEP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cnt[ufcd_pkg::VERTEX_W-1:0];
                o_mem.wdata = '{parent: r_cnt[ufcd_pkg::VERTEX_W-1:0], rank: '0};
                n_cnt       = ufcd_pkg::t_count'(r_cnt + 1'b1);
                if (n_cnt == r_limit) begin
                    n_state = S_IDLE;
                    if (r_report) begin
                        o_done.valid         = 1'b1;
                        o_done.result.status = ufcd_pkg::ST_CLEARED;
                    end
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_done.valid = 1'b1;
                    if (i_item.cmd == ufcd_pkg::CMD_CLEAR) begin
                        n_cycle              = 1'b0;
                        o_done.result.status = ufcd_pkg::ST_CLEARED;
                        if (i_active != '0) begin
                            // result comes at the end of the sweep
                            o_done.valid = 1'b0;
                            n_cnt        = '0;
                            n_limit      = i_active;
                            n_report     = 1'b1;
                            n_state      = S_SWEEP;
                        end
                    end else if (r_cycle) begin
                        o_done.result.status = ufcd_pkg::ST_SKIPPED;
                    end else if ({1'b0, i_item.first_vertex} >= i_active
                              || {1'b0, i_item.second_vertex} >= i_active) begin
                        o_done.result.status = ufcd_pkg::ST_RANGE;
                    end else if (i_item.first_vertex > i_item.second_vertex) begin
                        o_done.result.status = ufcd_pkg::ST_SKIPPED;
                    end else begin
                        o_done.valid = 1'b0;
                        n_phase      = 1'b0;
                        n_cur        = i_item.first_vertex;
                        n_start      = i_item.first_vertex;
                        n_v          = i_item.second_vertex;
                        n_state      = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_cur;
                n_state     = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (i_rdata.parent == r_cur) begin
                    n_root      = r_cur;
                    n_rank_root = i_rdata.rank;
                    if (!r_phase) begin
                        n_root_x = r_cur;
                        n_rank_x = i_rdata.rank;
                    end
                    if (r_start != r_cur) begin
                        n_cur   = r_start;
                        n_state = S_COMP_RD;
                    end else if (!r_phase) begin
                        n_phase = 1'b1;
                        n_cur   = r_v;
                        n_start = r_v;
                        n_state = S_FIND_RD;
                    end else begin
                        n_state = S_UNION;
                    end
                end else begin
                    // follow the link, next read issued at once
                    n_cur       = i_rdata.parent;
                    o_mem.re    = 1'b1;
                    o_mem.raddr = i_rdata.parent;
                end
            end
            S_COMP_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_cur;
                n_state     = S_COMP_CHK;
            end
            S_COMP_CHK: begin
                // repoint this vertex at the root, keep its rank
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cur;
                o_mem.wdata = '{parent: r_root, rank: i_rdata.rank};
                if (i_rdata.parent == r_root) begin
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_cur   = r_v;
                        n_start = r_v;
                        n_state = S_FIND_RD;
                    end else begin
                        n_state = S_UNION;
                    end
                end else begin
                    n_cur       = i_rdata.parent;
                    o_mem.re    = 1'b1;
                    o_mem.raddr = i_rdata.parent;
                end
            end
            S_UNION: begin
                o_done.result.status = ufcd_pkg::ST_JOINED;
                if (r_root_x == r_root) begin
                    n_cycle              = 1'b1;
                    o_done.valid         = 1'b1;
                    o_done.result.status = ufcd_pkg::ST_CYCLE;
                    n_state              = S_IDLE;
                end else if (r_rank_x < r_rank_root) begin
                    o_mem.we     = 1'b1;
                    o_mem.waddr  = r_root_x;
                    o_mem.wdata  = '{parent: r_root, rank: r_rank_x};
                    o_done.valid = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_root;
                    o_mem.wdata = '{parent: r_root_x, rank: r_rank_root};
                    if (r_rank_x > r_rank_root) begin
                        o_done.valid = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_TIE;
                    end
                end
            end
            S_TIE: begin
                // first root wins a tie and its rank grows, saturating
                o_mem.we             = 1'b1;
                o_mem.waddr          = r_root_x;
                o_mem.wdata.parent   = r_root_x;
                o_mem.wdata.rank     = (r_rank_x == ufcd_pkg::RANK_MAX)
                                     ? ufcd_pkg::RANK_MAX
                                     : ufcd_pkg::t_rank'(r_rank_x + 1'b1);
                o_done.valid         = 1'b1;
                o_done.result.status = ufcd_pkg::ST_JOINED;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_done.result.cycle_seen = n_cycle;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/union_find_cycle_detect.sv
// ----------------------------------------------------------------------------
// union_find_cycle_detect
// disjoint-set forest with union by rank and full path compression
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; each one gives
// exactly one result beat on o_result, marked by o_strobe for one cycle, and
// the receiver must take it then. After reset the block sweeps the whole
// forest (all 16384 vertices, busy high) before it takes the first command. A
// clear resets the active vertices, min(vertex_count, 16384), and then gives
// its result. Edges that are skipped or out of range answer from idle, with
// the result in the next cycle. A processed edge keeps the block busy while
// it walks each endpoint to its root, compresses the path of an endpoint that
// is not its own root, and does the union, with a further tie step on equal
// ranks; the result follows in the cycle after the last step. Every link
// step is one read of the forest memory; path compression keeps paths short.
// vertex_count may be written at any time the block is idle; o_cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module union_find_cycle_detect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ufcd_pkg::t_cmd    i_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  ufcd_pkg::t_count  i_cfg_data,
    output logic              o_strobe,
    output ufcd_pkg::t_result o_result
);

    // configuration: number of vertices in use
    ufcd_pkg::t_count   r_vertex_count;
    ufcd_pkg::t_count   active_count;

    // sequencer and memory
    ufcd_pkg::t_done    ctrl_done;
    ufcd_pkg::t_mem_req mem_req;
    ufcd_pkg::t_node    mem_rdata;
    logic               ctrl_busy;

    // result register
    logic               r_strobe;
    ufcd_pkg::t_result  r_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= ufcd_pkg::COUNT_FULL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // counts above the forest size are clipped
    assign active_count = (r_vertex_count > ufcd_pkg::COUNT_FULL)
                        ? ufcd_pkg::COUNT_FULL : r_vertex_count;

    ufcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_active (active_count),
        .o_busy   (ctrl_busy),
        .o_done   (ctrl_done),
        .o_mem    (mem_req),
        .i_rdata  (mem_rdata)
    );

    ufcd_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign busy = ctrl_busy;

    // one-cycle result beat, no back-pressure from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ctrl_done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_done.valid) begin
            r_result <= ctrl_done.result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // every accepted command either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted command neither answered nor in progress");

    // a reversed edge never reaches the forest
    a_reversed_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == ufcd_pkg::CMD_EDGE
         && i_item.first_vertex > i_item.second_vertex)
        |=> (o_strobe && (o_result.status == ufcd_pkg::ST_SKIPPED
                          || o_result.status == ufcd_pkg::ST_RANGE)))
        else $error("reversed edge was not skipped");

    // once a cycle is flagged, edges are skipped at once
    a_after_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && o_strobe && o_result.cycle_seen
         && i_item.cmd == ufcd_pkg::CMD_EDGE)
        |=> (o_strobe && o_result.status == ufcd_pkg::ST_SKIPPED
             && o_result.cycle_seen))
        else $error("edge after a cycle was processed");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the union-find cycle detector
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the disjoint-set forest: parent
// links, ranks, the sticky cycle flag and the vertex count. It works out the
// status of every command beat the block takes and checks each result strobe
// against the oldest outstanding one. A directed opening covers the extreme
// endpoints, self loops, reversed edges, edges once the cycle flag is set, out
// of range endpoints and the smallest counts. Random phases follow, each at a
// new vertex count written while the block is idle. Half of the random styles
// build spanning trees, each new edge sent reversed as well at random, with
// closing edges inside the tree; the rest send random pairs. All add noise.
// ----------------------------------------------------------------------------
module testbench;

    import ufcd_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int TOTAL_CMDS  = 1720;
    localparam int TAIL_CYCLES = 64;

    // ------------------------------------------------------------------------
    // scoreboard: private forest, expected result beats, mismatch count
    // ------------------------------------------------------------------------
    class forest_tracker;
        t_vertex link_tbl [MAX_VERTICES];
        t_rank   rank_tbl [MAX_VERTICES];
        bit      cycle_found;
        t_count  vcount;
        t_result due_results [$];
        int      faults;

        function new();
            for (int i = 0; i < MAX_VERTICES; i++) begin
                link_tbl[i] = t_vertex'(i);
                rank_tbl[i] = '0;
            end
            cycle_found = 1'b0;
            vcount      = COUNT_FULL;
            faults      = 0;
        endfunction

        function int active_count();
            return (int'(vcount) > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
        endfunction

        function void set_count(t_count val);
            vcount = val;
        endfunction

        // walk to the root, then point every vertex on the way straight at it
        function t_vertex find_root(t_vertex v);
            t_vertex r;
            t_vertex nxt;
            int      steps;
            r     = v;
            steps = 0;
            while (link_tbl[r] != r && steps < MAX_VERTICES) begin
                r = link_tbl[r];
                steps++;
            end
            steps = 0;
            while (v != r && steps < MAX_VERTICES) begin
                nxt         = link_tbl[v];
                link_tbl[v] = r;
                v           = nxt;
                steps++;
            end
            return r;
        endfunction

        function void take_command(t_cmd c);
            t_result want;
            t_vertex ra;
            t_vertex rb;
            int      n;
            n = active_count();
            if (c.cmd == CMD_CLEAR) begin
                for (int i = 0; i < n; i++) begin
                    link_tbl[i] = t_vertex'(i);
                    rank_tbl[i] = '0;
                end
                cycle_found = 1'b0;
                want.status = ST_CLEARED;
            end else if (cycle_found) begin
                want.status = ST_SKIPPED;
            end else if (int'(c.first_vertex) >= n || int'(c.second_vertex) >= n) begin
                want.status = ST_RANGE;
            end else if (c.first_vertex > c.second_vertex) begin
                want.status = ST_SKIPPED;
            end else begin
                ra = find_root(c.first_vertex);
                rb = find_root(c.second_vertex);
                if (ra == rb) begin
                    cycle_found = 1'b1;
                    want.status = ST_CYCLE;
                end else begin
                    if (rank_tbl[ra] > rank_tbl[rb]) begin
                        link_tbl[rb] = ra;
                    end else if (rank_tbl[ra] < rank_tbl[rb]) begin
                        link_tbl[ra] = rb;
                    end else begin
                        link_tbl[rb] = ra;
                        if (rank_tbl[ra] != RANK_MAX) begin
                            rank_tbl[ra] = rank_tbl[ra] + 1'b1;
                        end
                    end
                    want.status = ST_JOINED;
                end
            end
            want.cycle_seen = cycle_found;
            due_results.push_back(want);
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("unexpected result beat: status %0d cycle_seen %0b",
                             got.status, got.cycle_seen);
                end
            end else begin
                want = due_results.pop_front();
                if (want.status != got.status || want.cycle_seen != got.cycle_seen) begin
                    faults++;
                    if (faults <= 10) begin
                        $display({"mismatch: expected status %0d cycle_seen %0b,",
                                  " got status %0d cycle_seen %0b"},
                                 want.status, want.cycle_seen,
                                 got.status, got.cycle_seen);
                    end
                end
            end
        endfunction

        // anything still outstanding at the end never arrived
        function void close_out();
            if (due_results.size() != 0) begin
                faults += due_results.size();
                $display("%0d result beats never arrived", due_results.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block signals
    // ------------------------------------------------------------------------
    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_item;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    t_count  i_cfg_data;
    logic    o_strobe;
    t_result o_result;

    forest_tracker forest;
    int            cycle_count = 0;
    int            cmds_sent   = 0;
    bit            gaps_on     = 1'b1;

    // stimulus variables for the random phases
    int phase;
    int cnt;
    int n;
    int len;
    int style;
    int roll;
    int grown;
    int a;
    int b;

    union_find_cycle_detect DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // 20-unit clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog: the run time is dominated by the sweep after reset and the
    // full-size clears; the limit also covers every command being the slowest
    // clear its phase allows
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result beats cannot be held off, so every strobe is checked at once
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            forest.match_result(o_result);
        end
    end

    function automatic t_cmd edge_cmd(int u, int v);
        t_cmd c;
        c.cmd           = CMD_EDGE;
        c.first_vertex  = t_vertex'(u);
        c.second_vertex = t_vertex'(v);
        return c;
    endfunction

    // clear ignores the endpoints, so they carry random junk
    function automatic t_cmd clear_cmd();
        t_cmd c;
        c.cmd           = CMD_CLEAR;
        c.first_vertex  = t_vertex'($urandom_range(0, MAX_VERTICES - 1));
        c.second_vertex = t_vertex'($urandom_range(0, MAX_VERTICES - 1));
        return c;
    endfunction

    // drop start for the given number of cycles; entered and left at a falling edge
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // offer one command beat and hold it until the block takes it
    task automatic push_command(input t_cmd c);
        if (gaps_on && $urandom_range(0, 99) < 25) begin
            pause_sender($urandom_range(1, 5));
        end
        start  <= 1'b1;
        i_item <= c;
        do @(posedge i_clk); while (busy);
        forest.take_command(c);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    // hold off until every outstanding result beat has come back
    task automatic drain_results();
        start <= 1'b0;
        while (forest.due_results.size() != 0 || busy) begin
            @(negedge i_clk);
        end
    endtask

    // the count register is only written with the block idle
    task automatic write_vertex_count(input t_count val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        forest.set_count(val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        forest      = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --------------------------------------------------------------------
        // directed opening, full count straight after the reset sweep
        // --------------------------------------------------------------------
        push_command(edge_cmd(0, 16383));        // extreme endpoints, joined
        push_command(edge_cmd(16383, 0));        // reversed copy, skipped
        push_command(edge_cmd(8191, 8192));      // complementary bit patterns
        push_command(edge_cmd(0, 8192));         // tie of ranks, first root wins
        push_command(edge_cmd(16383, 16383));    // self loop, closes a cycle
        push_command(edge_cmd(1, 2));            // edge once the cycle flag is set
        push_command(clear_cmd());               // full-size clear

        // smallest sensible count
        write_vertex_count(t_count'(2));
        push_command(clear_cmd());
        push_command(edge_cmd(0, 2));            // second endpoint out of range
        push_command(edge_cmd(2, 0));            // range beats the reversal test
        push_command(edge_cmd(1, 0));            // reversed
        push_command(edge_cmd(0, 1));            // joined
        push_command(edge_cmd(0, 1));            // same set, cycle
        push_command(edge_cmd(16383, 0));        // cycle beats the range test

        // count of zero: nothing is in range
        write_vertex_count(t_count'(0));
        push_command(clear_cmd());
        push_command(edge_cmd(0, 0));

        // count of one: the only edge is a self loop
        write_vertex_count(t_count'(1));
        push_command(clear_cmd());
        push_command(edge_cmd(0, 0));

        // largest register value clamps to the full forest
        write_vertex_count(t_count'(32767));
        push_command(clear_cmd());
        push_command(edge_cmd(100, 16383));

        // count shrunk without a clear: old links above it stay put
        write_vertex_count(t_count'(4));
        push_command(edge_cmd(0, 3));
        push_command(edge_cmd(3, 4));

        // --------------------------------------------------------------------
        // random phases; phase 0 stays at the full count without a clear
        // --------------------------------------------------------------------
        phase = 0;
        while (cmds_sent < TOTAL_CMDS) begin
            // a run of phases with no gaps at all
            gaps_on = !(phase >= 8 && phase < 12);
            if (phase == 0) begin
                write_vertex_count(COUNT_FULL);
                style = 2;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    cnt = $urandom_range(0, 1);
                end else if (roll < 70) begin
                    cnt = $urandom_range(2, 16);
                end else if (roll < 92) begin
                    cnt = $urandom_range(17, 200);
                end else begin
                    cnt = $urandom_range(201, 1024);
                end
                write_vertex_count(t_count'(cnt));
                if ($urandom_range(0, 99) < 85) begin
                    push_command(clear_cmd());
                end
                style = $urandom_range(0, 3);
            end
            n     = forest.active_count();
            len   = $urandom_range(15, 50);
            grown = 1;
            for (int k = 0; k < len; k++) begin
                // sender waits for every outstanding result once, mid-phase
                if (phase == 6 && k == len / 2) begin
                    drain_results();
                end
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    push_command(clear_cmd());
                    grown = 1;
                end else if (roll < 12 || n < 2) begin
                    // noise: arbitrary endpoints over the whole field width
                    push_command(edge_cmd($urandom_range(0, MAX_VERTICES - 1),
                                          $urandom_range(0, MAX_VERTICES - 1)));
                end else if (style <= 1) begin
                    // spanning tree: each new vertex hangs off an older one
                    if (forest.cycle_found && $urandom_range(0, 1) == 0) begin
                        push_command(clear_cmd());
                        grown = 1;
                    end else if (grown < n && $urandom_range(0, 99) >= 6) begin
                        a = $urandom_range(0, grown - 1);
                        push_command(edge_cmd(a, grown));
                        if ($urandom_range(0, 1) == 1) begin
                            push_command(edge_cmd(grown, a));
                        end
                        grown++;
                    end else begin
                        // closing edge inside what has been built so far
                        a = $urandom_range(0, grown - 1);
                        b = $urandom_range(a, grown - 1);
                        push_command(edge_cmd(a, b));
                    end
                end else begin
                    // random pair inside the count, either orientation
                    push_command(edge_cmd($urandom_range(0, n - 1), $urandom_range(0, n - 1)));
                end
            end
            phase++;
        end

        // --------------------------------------------------------------------
        // wind down: everything back, then a quiet tail for stray beats
        // --------------------------------------------------------------------
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        forest.close_out();
        if (forest.faults == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ufcd_pkg.sv
rtl/core/ufcd_mem.sv
rtl/core/ufcd_ctrl.sv
rtl/core/union_find_cycle_detect.sv
tb/testbench.sv
